// ===== design/cdf_table_bin_search_defines.svh =====
// assertion macros for the inverse-cdf bin search block
// used by the top level only; needs nothing else
`ifndef CDF_TABLE_BIN_SEARCH_DEFINES_SVH
`define CDF_TABLE_BIN_SEARCH_DEFINES_SVH

// implication checked in the same cycle
`define CDFBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cdfbs: same-cycle check failed");

// implication checked in the next cycle
`define CDFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cdfbs: next-cycle check failed");

`endif

// ===== design/cdfbs_pkg.sv =====
// shared types and constants of the inverse-cdf bin search block
// no dependencies; imported by the interfaces, the compare unit and the top level
`default_nettype none

package cdfbs_pkg;

	localparam int VAL_W       = 17;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int TABLE_DEPTH = 64;
	localparam int LANES       = 8;
	localparam int LANE_W      = $clog2(LANES);
	localparam int ROWS        = TABLE_DEPTH / LANES;
	localparam int ROW_W       = $clog2(ROWS);

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LAST = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	// outcome of comparing one table row against the threshold
	typedef struct packed {
		logic              hit;
		logic [LANE_W-1:0] lane;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== design/cdfbs_ifs.sv =====
// valid/ready channel interfaces for the input items and the results
// depends on cdfbs_pkg
`default_nettype none

interface cdfbs_in_if import cdfbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [IDX_W-1:0] entry_index;
	logic [VAL_W-1:0] entry_value;
	logic [VAL_W-1:0] probe;

	modport source (output valid, func, entry_index, entry_value, probe, input ready);
	modport sink (input valid, func, entry_index, entry_value, probe, output ready);
endinterface

interface cdfbs_out_if import cdfbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] bin_index;
	logic             above_all;

	modport source (output valid, bin_index, above_all, input ready);
	modport sink (input valid, bin_index, above_all, output ready);
endinterface

`default_nettype wire

// ===== design/cdfbs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module cdfbs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/cdfbs_row_cmp.sv =====
// compare unit: checks one row of table entries against a threshold
// and returns the lowest lane in use whose entry is at least it; uses cdfbs_pkg
`default_nettype none

module cdfbs_row_cmp import cdfbs_pkg::*; (
	input  wire logic [VAL_W-1:0] row_data [LANES],
	input  wire logic [VAL_W-1:0] thr,
	input  wire logic [ROW_W-1:0] row,
	input  wire logic [IDX_W-1:0] last_idx,
	output cmp_res_t              res
);

	logic [LANES-1:0] mask;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mask[i] = (row_data[i] >= thr) && ({row, LANE_W'(i)} <= last_idx);
		end
	end

	always_comb begin
		res.hit  = |mask;
		res.lane = '0;
		// lowest set lane wins
		for (int i = LANES - 1; i >= 0; i--) begin
			if (mask[i]) begin
				res.lane = LANE_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/cdf_table_bin_search.sv =====
// Inverse-cdf bin search over a cumulative Q1.16 table of up to 64 entries.
// Input channel "item": func selects a table write (entry_index, entry_value)
// or a lookup (probe). Output channel "result": bin_index and above_all, one
// transfer per lookup, none per write. cfg_we/cfg_data set entry_count.
// The table sits in 8 banks of 8 rows; one shared 8-lane compare unit checks
// a whole row per cycle, lowest row first.
// Sequence: a write is taken while idle and the block stays ready for the
// next item. A lookup first reads the row holding the last entry in use
// (state LAST), then, unless the probe is above that entry, scans rows from
// the lowest (state SCAN) until a hit or the last row in use, then loads the
// output register (state OUT) once it is free or being taken, and returns to
// idle; the input is not ready for the next item until then.
// The output register frees the input side: a new item is accepted while a
// result waits; a stalled receiver holds the block only if a second result
// is finished before the first is taken.
// Reset clears control and sets entry_count to 1; table contents are
// undefined until written.
`include "cdf_table_bin_search_defines.svh"
`default_nettype none

module cdf_table_bin_search import cdfbs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data,
	cdfbs_in_if.sink              item,
	cdfbs_out_if.source           result
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_q, n_d;
	logic [IDX_W-1:0] last_idx_q;
	logic [ROW_W-1:0] last_row_q;
	logic [VAL_W-1:0] probe_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] bin_q;
	logic             above_q;
	logic             out_vld_q;
	logic [CNT_W-1:0] out_bin_q;
	logic             out_above_q;

	logic             in_xfer;
	logic             wr_en;
	logic             lookup_go;
	logic [IDX_W-1:0] last_idx_d;
	logic [ROW_W-1:0] rd_addr;
	logic [VAL_W-1:0] rd_data [LANES];
	logic [VAL_W-1:0] thr;
	logic             above_now;
	logic             out_load;
	cmp_res_t         cmp;

	assign item.ready = (state_q == ST_IDLE);
	assign in_xfer    = item.valid && item.ready;
	assign wr_en      = in_xfer && (item.func == FUNC_WRITE);
	assign lookup_go  = in_xfer && (item.func == FUNC_LOOKUP);

	// effective count, clamped to 1 .. depth
	always_comb begin
		if (count_q == '0) begin
			n_d = CNT_W'(1);
		end else if (count_q > CNT_W'(TABLE_DEPTH)) begin
			n_d = CNT_W'(TABLE_DEPTH);
		end else begin
			n_d = count_q;
		end
	end
	assign last_idx_d = IDX_W'(n_d - CNT_W'(1));

	// zero probe looks for the first entry above zero
	assign thr       = (probe_q == '0) ? VAL_W'(1) : probe_q;
	assign above_now = probe_q > rd_data[last_idx_q[LANE_W-1:0]];

	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = last_idx_d[IDX_W-1:LANE_W];
			ST_LAST: rd_addr = '0;
			ST_SCAN: rd_addr = row_q + ROW_W'(1);
			ST_OUT:  rd_addr = '0;
			default: rd_addr = '0;
		endcase
	end

	for (genvar b = 0; b < LANES; b++) begin : g_bank
		cdfbs_ram #(
			.WIDTH(VAL_W),
			.DEPTH(ROWS)
		) u_bank (
			.clk  (clk),
			.we   (wr_en && (item.entry_index[LANE_W-1:0] == LANE_W'(b))),
			.waddr(item.entry_index[IDX_W-1:LANE_W]),
			.wdata(item.entry_value),
			.raddr(rd_addr),
			.rdata(rd_data[b])
		);
	end

	cdfbs_row_cmp u_cmp (
		.row_data(rd_data),
		.thr     (thr),
		.row     (row_q),
		.last_idx(last_idx_q),
		.res     (cmp)
	);

	assign out_load = (state_q == ST_OUT) && (!out_vld_q || result.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (lookup_go) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = above_now ? ST_OUT : ST_SCAN;
			end
			ST_SCAN: begin
				if (cmp.hit || (row_q == last_row_q)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= CNT_W'(1);
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_go) begin
			n_q        <= n_d;
			last_idx_q <= last_idx_d;
			last_row_q <= last_idx_d[IDX_W-1:LANE_W];
			probe_q    <= item.probe;
		end
		if (state_q == ST_LAST) begin
			row_q   <= '0;
			bin_q   <= n_q;
			above_q <= above_now;
		end
		if (state_q == ST_SCAN) begin
			row_q <= row_q + ROW_W'(1);
			if (cmp.hit) begin
				bin_q <= CNT_W'({row_q, cmp.lane});
			end
		end
		if (out_load) begin
			out_bin_q   <= bin_q;
			out_above_q <= above_q;
		end
	end

	assign result.valid     = out_vld_q;
	assign result.bin_index = out_bin_q;
	assign result.above_all = out_above_q;

	`CDFBS_ASSERT_NEXT(a_out_loaded, clk, arst_n, out_load, result.valid)
	`CDFBS_ASSERT_NOW(a_above_bin, clk, arst_n, (state_q == ST_OUT) && above_q, bin_q == n_q)
	`CDFBS_ASSERT_NOW(a_scan_row, clk, arst_n, state_q == ST_SCAN, row_q <= last_row_q)

endmodule

`default_nettype wire
